// ===== src/mtwa_pkg.sv =====
// ----------------------------------------------------------------------------
// mtwa_pkg
// Shared widths, reset values and register codes of the light level filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mtwa_pkg;

	localparam int SAMPLE_W        = 18;
	localparam int WEIGHT_W        = 7;
	localparam int AVG_TAPS        = 4;
	localparam int WSUM_W          = WEIGHT_W + $clog2(AVG_TAPS);
	localparam int ACC_W           = SAMPLE_W + WSUM_W;
	localparam int CNT_W           = $clog2(SAMPLE_W);
	localparam int CFG_IDX_W       = 4;
	localparam int DEF_MEDIAN_TAPS = 5;

	localparam logic [SAMPLE_W-1:0] LEVEL_AT_RESET = SAMPLE_W'(76);

	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET [AVG_TAPS] = '{
		WEIGHT_W'(50), WEIGHT_W'(25), WEIGHT_W'(15), WEIGHT_W'(10)
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WEIGHT_NEWEST = CFG_IDX_W'(0),
		REG_WEIGHT_SECOND = CFG_IDX_W'(1),
		REG_WEIGHT_THIRD  = CFG_IDX_W'(2),
		REG_WEIGHT_OLDEST = CFG_IDX_W'(3)
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== src/mtwa_if.sv =====
// ----------------------------------------------------------------------------
// mtwa_in_if / mtwa_out_if
// Valid/ready channels carrying light samples in and filtered levels out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtwa_in_if import mtwa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic                sensor_error;

	modport source (output valid, sample, sensor_error, input ready);
	modport sink   (input valid, sample, sensor_error, output ready);
endinterface

interface mtwa_out_if import mtwa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] level;
	logic                error;

	modport source (output valid, level, error, input ready);
	modport sink   (input valid, level, error, output ready);
endinterface

`default_nettype wire

// ===== src/median_then_weighted_average.sv =====
// ----------------------------------------------------------------------------
// median_then_weighted_average
// Median of the last good samples, then a weighted average of the last four
// medians, worked out one bit per cycle.
// ----------------------------------------------------------------------------
// Samples arrive on in_ch and one result per sample leaves on out_ch. A
// transfer takes place on a clock edge at which valid and ready are both
// high. The user writes the weights through wr_en, wr_index and wr_data only
// while idle; the block does not enforce it. Indexes above three are ignored.
// A sample flagged as a sensor error repeats the previous level with error
// set and goes straight to the output state ST_OUT. A good sample passes a
// bit-serial rank sort for the median (ST_MED), a state that picks it
// (ST_SEL), a bit-serial weighted sum (ST_MUL), a set-up state (ST_DSET)
// and a restoring division (ST_DIV) before its result is offered from
// ST_OUT. With all weights zero the division is skipped.
// One sample is in work at a time. The result moves into the output
// register once that register is empty or its result leaves at the same
// edge, and in_ch is ready again from then on.
// A stalled receiver holds the result register, and the block stops once it
// has the next result ready.
// Reset clears both windows, sets the last level to 19.0 lux and loads the
// default weights.
// ----------------------------------------------------------------------------
`default_nettype none

module median_then_weighted_average import mtwa_pkg::*; #(
	parameter int MEDIAN_TAPS = DEF_MEDIAN_TAPS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [WEIGHT_W-1:0]  wr_data,
	mtwa_in_if.sink                   in_ch,
	mtwa_out_if.source                out_ch
);

	localparam int RANK_W = $clog2(MEDIAN_TAPS);
	localparam int MID    = MEDIAN_TAPS / 2;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MED,
		ST_SEL,
		ST_MUL,
		ST_DSET,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [SAMPLE_W-1:0] win_q [MEDIAN_TAPS];
	logic                dec_q [MEDIAN_TAPS][MEDIAN_TAPS];
	logic                lt_q  [MEDIAN_TAPS][MEDIAN_TAPS];
	logic [SAMPLE_W-1:0] avg_q [AVG_TAPS];
	logic [WEIGHT_W-1:0] weight_q [AVG_TAPS];
	logic [WSUM_W-1:0]   wsum_q;
	logic [ACC_W-1:0]    acc_q;
	logic [WSUM_W-1:0]   rem_q;
	logic [SAMPLE_W-1:0] quo_q;
	logic [SAMPLE_W-1:0] last_level_q;
	logic                err_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_level_q;
	logic                out_error_q;

	logic [RANK_W-1:0]   rank    [MEDIAN_TAPS];
	logic [SAMPLE_W-1:0] median;
	logic [WSUM_W-1:0]   wbits;
	logic [WSUM_W-1:0]   wsum;
	logic [WSUM_W:0]     trial;
	logic [WSUM_W:0]     diff;
	logic                ge;
	logic                in_take;

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign in_take      = in_ch.valid && (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.level = out_level_q;
	assign out_ch.error = out_error_q;

	// Stable rank of each window entry; ties are broken by position.
	always_comb begin
		median = '0;
		for (int i = 0; i < MEDIAN_TAPS; i++) begin
			rank[i] = '0;
			for (int j = 0; j < MEDIAN_TAPS; j++) begin
				if (j != i) begin
					if ((dec_q[j][i] && lt_q[j][i]) || (j < i && !dec_q[j][i])) begin
						rank[i] = rank[i] + RANK_W'(1);
					end
				end
			end
			if (rank[i] == RANK_W'(MID)) begin
				median = win_q[i];
			end
		end
	end

	always_comb begin
		wbits = '0;
		wsum  = '0;
		for (int i = 0; i < AVG_TAPS; i++) begin
			wsum = wsum + WSUM_W'(weight_q[i]);
			if (avg_q[i][SAMPLE_W-1]) begin
				wbits = wbits + WSUM_W'(weight_q[i]);
			end
		end
		trial = {rem_q, quo_q[SAMPLE_W-1]};
		diff  = trial - {1'b0, wsum_q};
		ge    = (trial >= {1'b0, wsum_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			last_level_q <= LEVEL_AT_RESET;
			err_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < MEDIAN_TAPS; i++) begin
				win_q[i] <= '0;
			end
			for (int i = 0; i < AVG_TAPS; i++) begin
				avg_q[i]    <= '0;
				weight_q[i] <= WEIGHT_RESET[i];
			end
		end else begin
			if (out_valid_q && out_ch.ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end

			if (wr_en) begin
				case (cfg_reg_t'(wr_index))
					REG_WEIGHT_NEWEST: weight_q[0] <= wr_data;
					REG_WEIGHT_SECOND: weight_q[1] <= wr_data;
					REG_WEIGHT_THIRD:  weight_q[2] <= wr_data;
					REG_WEIGHT_OLDEST: weight_q[3] <= wr_data;
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						err_q <= in_ch.sensor_error;
						cnt_q <= '0;
						if (in_ch.sensor_error) begin
							state_q <= ST_OUT;
						end else begin
							win_q[0] <= in_ch.sample;
							for (int i = 1; i < MEDIAN_TAPS; i++) begin
								win_q[i] <= win_q[i-1];
							end
							for (int i = 0; i < MEDIAN_TAPS; i++) begin
								for (int j = 0; j < MEDIAN_TAPS; j++) begin
									dec_q[i][j] <= 1'b0;
									lt_q[i][j]  <= 1'b0;
								end
							end
							state_q <= ST_MED;
						end
					end
				end
				ST_MED: begin
					for (int i = 0; i < MEDIAN_TAPS; i++) begin
						win_q[i] <= {win_q[i][SAMPLE_W-2:0], win_q[i][SAMPLE_W-1]};
						for (int j = 0; j < MEDIAN_TAPS; j++) begin
							if (!dec_q[i][j] &&
							    (win_q[i][SAMPLE_W-1] != win_q[j][SAMPLE_W-1])) begin
								dec_q[i][j] <= 1'b1;
								lt_q[i][j]  <= win_q[j][SAMPLE_W-1];
							end
						end
					end
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					avg_q[0] <= median;
					for (int i = 1; i < AVG_TAPS; i++) begin
						avg_q[i] <= avg_q[i-1];
					end
					wsum_q  <= wsum;
					acc_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					for (int i = 0; i < AVG_TAPS; i++) begin
						avg_q[i] <= {avg_q[i][SAMPLE_W-2:0], avg_q[i][SAMPLE_W-1]};
					end
					acc_q <= {acc_q[ACC_W-2:0], 1'b0} + ACC_W'(wbits);
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_DSET;
					end
				end
				ST_DSET: begin
					rem_q <= acc_q[ACC_W-1:SAMPLE_W];
					quo_q <= acc_q[SAMPLE_W-1:0];
					cnt_q <= '0;
					if (wsum_q == '0) begin
						last_level_q <= '0;
						state_q      <= ST_OUT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= ge ? diff[WSUM_W-1:0] : trial[WSUM_W-1:0];
					quo_q <= {quo_q[SAMPLE_W-2:0], ge};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_LAST) begin
						last_level_q <= {quo_q[SAMPLE_W-2:0], ge};
						state_q      <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_level_q <= last_level_q;
						out_error_q <= err_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
